// File: rtl/spt_pkg.sv
package spt_pkg;

  // Input command codes
  localparam logic CMD_BUILD  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Configuration register indexes
  localparam logic REG_SEED  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam int unsigned SEED_W  = 32;
  localparam int unsigned VALUE_W = 10;
  localparam int unsigned PROD_W  = SEED_W + VALUE_W;

  localparam logic [SEED_W-1:0]  SEED_RESET  = '0;
  localparam logic [VALUE_W-1:0] COUNT_RESET = 10'd493;

  typedef logic [SEED_W-1:0]  seed_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [PROD_W-1:0]  prod_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_LOOK = 11'b000_0000_0010,
    S_FILL = 11'b000_0000_0100,
    S_MUL  = 11'b000_0000_1000,
    S_MIX  = 11'b000_0001_0000,
    S_DIV  = 11'b000_0010_0000,
    S_RDA  = 11'b000_0100_0000,
    S_RDB  = 11'b000_1000_0000,
    S_WRA  = 11'b001_0000_0000,
    S_WRB  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

endpackage

// File: rtl/seeded_permutation_table_top.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_cmd, in_key
// out_     output     out_valid/out_stall  out_mapped_value, out_status
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A lookup takes equally long to its result, whether it hits, has key zero or is out of range.
// A build fills the identity into the n active entries, then runs n-1 shuffle passes:
// each pass is one multiply, one mix, a 32-step one-bit-a-cycle remainder loop and a
// swap of two reads and two writes through the single read port and single write port of the table.
// rst_n is synchronous; it clears control and the mix seed, the table holds
// garbage until the first build. A stalled result holds in the output register;
// the block still takes one more item and then waits in its finishing state
// until the register frees.
module seeded_permutation_table_top
  import spt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [VALUE_W-1:0] in_key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_mapped_value,
  output logic               out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [SEED_W-1:0]  cfg_data
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned XW = (AW > VALUE_W) ? AW : VALUE_W;
  localparam logic [VALUE_W-1:0] MAX_CNT =
    (MAX_ENTRIES > 1023) ? 10'd1023 : VALUE_W'(MAX_ENTRIES);

  function automatic logic [AW-1:0] to_addr(input logic [VALUE_W-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return w[AW-1:0];
  endfunction

  state_t       state_r, state_nxt;
  seed_t        shuffle_seed_r;
  value_t       entry_count_r;
  seed_t        seed_r;
  seed_t        div_r;
  prod_t        prod_r;
  value_t       n_r;
  value_t       cnt_r;
  value_t       i_r;
  value_t       rem_r;
  logic [4:0]   bit_r;
  value_t       tmp_r;
  value_t       rdata_r;
  value_t       res_val_r;
  logic         res_status_r;
  logic         out_valid_r;
  value_t       out_val_r;
  logic         out_status_r;

  logic [VALUE_W-1:0] mem [MAX_ENTRIES];

  value_t       n_cur;
  logic         in_acc;
  logic         out_free;
  logic         out_load;
  value_t       out_load_val;
  logic         out_load_status;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  value_t       wdata;
  logic         we;
  logic [VALUE_W:0] trial;
  logic [VALUE_W:0] trial_sub;

  assign n_cur     = (entry_count_r > MAX_CNT) ? MAX_CNT : entry_count_r;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_mapped_value = out_val_r;
  assign out_status       = out_status_r;

  // one remainder step: shift in the next seed bit, subtract i when it fits
  assign trial     = {rem_r, div_r[SEED_W-1]};
  assign trial_sub = trial - {1'b0, i_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_BUILD) begin
            state_nxt = (n_cur == '0) ? S_DONE : S_FILL;
          end else if (in_key != '0 && in_key <= n_cur) begin
            state_nxt = S_LOOK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_LOOK: state_nxt = out_free ? S_IDLE : S_DONE;
      S_FILL: begin
        if (cnt_r + 10'd1 == n_r) begin
          state_nxt = (n_r > 10'd1) ? S_MUL : S_DONE;
        end
      end
      S_MUL:  state_nxt = S_MIX;
      S_MIX:  state_nxt = S_DIV;
      S_DIV:  state_nxt = (bit_r == 5'd31) ? S_RDA : S_DIV;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_WRA;
      S_WRA:  state_nxt = S_WRB;
      S_WRB:  state_nxt = (i_r == 10'd2) ? S_DONE : S_MUL;
      S_DONE: state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // table port selection
  always_comb begin
    raddr = '0;
    waddr = '0;
    wdata = '0;
    we    = 1'b0;
    unique case (state_r)
      S_IDLE: raddr = to_addr(in_key - 10'd1);
      S_RDA:  raddr = to_addr(rem_r);
      S_RDB:  raddr = to_addr(i_r - 10'd1);
      S_FILL: begin
        we    = 1'b1;
        waddr = to_addr(cnt_r);
        wdata = cnt_r + 10'd1;
      end
      S_WRA: begin
        we    = 1'b1;
        waddr = to_addr(rem_r);
        wdata = rdata_r;
      end
      S_WRB: begin
        we    = 1'b1;
        waddr = to_addr(i_r - 10'd1);
        wdata = tmp_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    out_load        = 1'b0;
    out_load_val    = res_val_r;
    out_load_status = res_status_r;
    if (state_r == S_LOOK && out_free) begin
      out_load        = 1'b1;
      out_load_val    = rdata_r;
      out_load_status = STATUS_OK;
    end else if (state_r == S_DONE && out_free) begin
      out_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      shuffle_seed_r <= SEED_RESET;
      entry_count_r  <= COUNT_RESET;
      seed_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SEED:  shuffle_seed_r <= cfg_data;
          REG_COUNT: entry_count_r  <= cfg_data[VALUE_W-1:0];
          default: ;
        endcase
      end

      if (state_r == S_IDLE && in_acc && in_cmd == CMD_BUILD) begin
        seed_r <= shuffle_seed_r;
      end else if (state_r == S_MIX) begin
        seed_r <= seed_r ^ prod_r[SEED_W-1:0]
                         ^ SEED_W'(prod_r[PROD_W-1:SEED_W]);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_r    <= out_load_val;
      out_status_r <= out_load_status;
    end
    case (state_r)
      S_IDLE: begin
        n_r   <= n_cur;
        cnt_r <= '0;
        i_r   <= n_cur;
        res_val_r    <= '0;
        res_status_r <= (in_cmd == CMD_LOOKUP && in_key > n_cur) ? STATUS_RANGE
                                                                 : STATUS_OK;
      end
      S_LOOK: res_val_r <= rdata_r;
      S_FILL: cnt_r <= cnt_r + 10'd1;
      S_MUL:  prod_r <= PROD_W'(i_r) * PROD_W'(seed_r);
      S_MIX: begin
        div_r <= seed_r ^ prod_r[SEED_W-1:0] ^ SEED_W'(prod_r[PROD_W-1:SEED_W]);
        rem_r <= '0;
        bit_r <= '0;
      end
      S_DIV: begin
        div_r <= {div_r[SEED_W-2:0], 1'b0};
        bit_r <= bit_r + 5'd1;
        if (!trial_sub[VALUE_W]) begin
          rem_r <= trial_sub[VALUE_W-1:0];
        end else begin
          rem_r <= trial[VALUE_W-1:0];
        end
      end
      S_RDB:  tmp_r <= rdata_r;
      S_WRB: begin
        i_r       <= i_r - 10'd1;
        res_val_r <= '0;
      end
      default: ;
    endcase
  end

  property p_rem_below_i;
    @(posedge clk) disable iff (!rst_n)
      (state_r == S_DIV || state_r == S_RDA) |-> (rem_r < i_r);
  endproperty
  a_rem_below_i: assert property (p_rem_below_i)
    else $error("remainder not below pass index");

  property p_mul_index;
    @(posedge clk) disable iff (!rst_n)
      (state_r == S_MUL) |-> (i_r >= 10'd2 && i_r <= n_r);
  endproperty
  a_mul_index: assert property (p_mul_index)
    else $error("shuffle pass index out of range");

  property p_range_zero;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_status_r == STATUS_RANGE) |-> (out_val_r == '0);
  endproperty
  a_range_zero: assert property (p_range_zero)
    else $error("error result carries a nonzero value");

  property p_out_source;
    @(posedge clk) disable iff (!rst_n)
      $rose(out_valid_r) |-> $past(state_r == S_LOOK || state_r == S_DONE);
  endproperty
  a_out_source: assert property (p_out_source)
    else $error("result produced outside a finishing state");

endmodule

// File: verif/seeded_permutation_table_top_tb.sv
`timescale 1ns / 1ps

module seeded_permutation_table_top_tb;
  import spt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 512;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned PHASES = 30;
  localparam int unsigned PHASE_ITEMS = 30;

  typedef struct packed {
    logic   cmd;
    value_t key;
  } perm_req_t;

  typedef struct packed {
    value_t mapped;
    logic   status;
  } perm_resp_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic         in_cmd = CMD_LOOKUP;
  value_t       in_key = '0;
  logic         out_valid;
  logic         out_stall;
  value_t       out_mapped_value;
  logic         out_status;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = REG_SEED;
  seed_t        cfg_data = '0;

  logic         rx_stall = 1'b0;
  logic         long_hold = 1'b0;

  assign out_stall = rx_stall | long_hold;

  seeded_permutation_table_top #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_key           (in_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mapped_value (out_mapped_value),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Shadow of the block: registers and the permutation table
  seed_t       shadow_seed = SEED_RESET;
  value_t      shadow_count = COUNT_RESET;
  value_t      shadow_perm [TABLE_DEPTH];
  seed_t       shadow_mix = '0;

  perm_req_t   req_q [$];
  perm_resp_t  result_q [$];
  perm_req_t   cur_req;

  int unsigned idle_max = 19;
  int unsigned send_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned gen_written = 0;

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_builds = 0;
  int unsigned n_hits = 0;
  int unsigned n_range = 0;
  int unsigned n_zero = 0;
  int unsigned n_cfg = 0;
  longint      cycle_budget = 0;
  longint      cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned active_entries(value_t count);
    return (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
  endfunction

  // Build the identity, then run the seeded shuffle from the top entry down
  task automatic shuffle_table();
    int unsigned n;
    logic [63:0] prod;
    int unsigned j;
    value_t      swap;
    n = active_entries(shadow_count);
    for (int unsigned x = 0; x < n; x++)
      shadow_perm[x] = value_t'(x + 1);
    shadow_mix = shadow_seed;
    for (int unsigned i = n; i > 1; i--) begin
      prod = 64'(i) * 64'(shadow_mix);
      shadow_mix = shadow_mix ^ prod[31:0];
      shadow_mix = shadow_mix ^ prod[63:32];
      j = shadow_mix % i;
      swap = shadow_perm[j];
      shadow_perm[j] = shadow_perm[i-1];
      shadow_perm[i-1] = swap;
    end
  endtask

  task automatic predict_perm(input perm_req_t req);
    perm_resp_t resp;
    resp.mapped = '0;
    resp.status = STATUS_OK;
    if (req.cmd == CMD_BUILD) begin
      shuffle_table();
      n_builds++;
    end else if (req.key == '0) begin
      n_zero++;
    end else if (req.key > active_entries(shadow_count)) begin
      resp.status = STATUS_RANGE;
      n_range++;
    end else begin
      resp.mapped = shadow_perm[req.key - 1];
      n_hits++;
    end
    result_q.push_back(resp);
  endtask

  // Sender: hold a stalled item, otherwise wait out the drawn gap and send the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_perm(cur_req);
        n_accepted++;
        send_gap = $urandom_range(0, idle_max);
      end
      if (in_valid && in_stall) begin
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        cur_req = req_q.pop_front();
        in_cmd <= cur_req.cmd;
        in_key <= cur_req.key;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: compare each result with the oldest expectation, then draw a stall
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (result_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result: value %0d status %0d", $time,
                   out_mapped_value, out_status);
        end else begin
          perm_resp_t want;
          want = result_q.pop_front();
          if (out_mapped_value !== want.mapped) begin
            n_errors++;
            $display("%0t: mapped_value: expected %0d, got %0d", $time,
                     want.mapped, out_mapped_value);
          end
          if (out_status !== want.status) begin
            n_errors++;
            $display("%0t: status: expected %0d, got %0d", $time,
                     want.status, out_status);
          end
        end
        rx_wait = $urandom_range(0, idle_max);
      end
      if (rx_wait != 0) begin
        rx_wait--;
        rx_stall <= 1'b1;
      end else begin
        rx_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the block backs up into its input;
  // start it once a result is on offer
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold <= 1'b0;
      hold_left = 0;
    end else if (hold_left != 0) begin
      hold_left--;
      long_hold <= (hold_left != 0);
    end else if (hold_served != hold_asked && out_valid) begin
      hold_served++;
      hold_left = LONG_HOLD;
      long_hold <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 4 * cycle_budget + 20000) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_item(input logic cmd, input value_t key);
    int unsigned eff;
    perm_req_t   req;
    eff = active_entries(shadow_count);
    req.cmd = cmd;
    req.key = key;
    if (cmd == CMD_BUILD) begin
      if (eff > gen_written)
        gen_written = eff;
      cycle_budget += 41 * eff + 64;
    end
    cycle_budget += 48;
    req_q.push_back(req);
    n_queued++;
  endtask

  // Never aim a lookup at an entry that no build has written yet
  function automatic value_t pick_key();
    int unsigned eff;
    int unsigned known;
    int unsigned roll;
    int unsigned k;
    eff = active_entries(shadow_count);
    known = (eff < gen_written) ? eff : gen_written;
    roll = $urandom_range(0, 99);
    if (roll < 70 && known != 0)
      return value_t'($urandom_range(1, known));
    if (roll < 80)
      return '0;
    k = $urandom_range(0, 1023);
    if (k != 0 && k <= eff && k > gen_written)
      k = eff + 1;
    return value_t'(k);
  endfunction

  task automatic write_reg(input logic idx, input seed_t data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SEED)
      shadow_seed = data;
    else
      shadow_count = data[VALUE_W-1:0];
    n_cfg++;
  endtask

  // Upper data bits of the count write are don't-care; randomize them
  task automatic set_config(input seed_t seed, input value_t count);
    seed_t data;
    data = $urandom();
    data[VALUE_W-1:0] = count;
    write_reg(REG_SEED, seed);
    write_reg(REG_COUNT, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (n_accepted != n_queued || result_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    seed_t       seed;
    value_t      count;
    int unsigned eff;
    bit          noisy;
    for (int i = 0; i < TABLE_DEPTH; i++)
      shadow_perm[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: lookups on an unbuilt table, then a full build
    push_item(CMD_LOOKUP, 10'd0);
    push_item(CMD_LOOKUP, 10'd1023);
    push_item(CMD_LOOKUP, 10'd494);
    push_item(CMD_BUILD, 10'd0);
    push_item(CMD_LOOKUP, 10'd1);
    push_item(CMD_LOOKUP, 10'd493);
    push_item(CMD_LOOKUP, 10'd250);
    drain();

    // Count above the table saturates
    set_config(32'hffff_ffff, 10'd1023);
    push_item(CMD_BUILD, 10'd1023);
    push_item(CMD_LOOKUP, 10'd512);
    push_item(CMD_LOOKUP, 10'd1);
    push_item(CMD_LOOKUP, 10'd513);
    push_item(CMD_LOOKUP, 10'd0);
    drain();

    // Counts below two: no shuffle passes; a count of two: a single pass
    set_config('0, 10'd0);
    push_item(CMD_BUILD, 10'd0);
    push_item(CMD_LOOKUP, 10'd1);
    push_item(CMD_LOOKUP, 10'd0);
    drain();
    set_config($urandom(), 10'd1);
    push_item(CMD_BUILD, 10'd0);
    push_item(CMD_LOOKUP, 10'd1);
    push_item(CMD_LOOKUP, 10'd2);
    drain();
    set_config($urandom(), 10'd2);
    push_item(CMD_BUILD, 10'd0);
    push_item(CMD_LOOKUP, 10'd1);
    push_item(CMD_LOOKUP, 10'd2);
    push_item(CMD_LOOKUP, 10'd3);
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      idle_max = (p % 7 == 3) ? 0 : 19;
      if (p % 11 == 0)
        seed = '0;
      else if (p % 11 == 5)
        seed = 32'hffff_ffff;
      else
        seed = $urandom();
      case (p)
        4:       count = 10'd512;
        9:       count = value_t'($urandom_range(513, 1023));
        14:      count = 10'd1;
        19:      count = 10'd0;
        24:      count = value_t'($urandom_range(256, 511));
        default: count = value_t'($urandom_range(2, 48));
      endcase
      set_config(seed, count);
      eff = active_entries(shadow_count);
      noisy = (p % 10 == 7);
      if (!noisy)
        push_item(CMD_BUILD, value_t'($urandom_range(0, 1023)));
      for (int unsigned k = 1; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 10 && eff <= 64)
          push_item(CMD_BUILD, value_t'($urandom_range(0, 1023)));
        else
          push_item(CMD_LOOKUP, pick_key());
      end
      if (p == 6 || p == 21) begin
        cycle_budget += LONG_HOLD;
        hold_asked++;
      end
      drain();
    end

    $display("Ran %0d items: %0d builds, %0d in-range lookups, %0d out-of-range, %0d zero keys",
             n_accepted, n_builds, n_hits, n_range, n_zero);
    $display("Checked %0d results across %0d register writes", n_results, n_cfg);
    if (n_errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: seeded_permutation_table_top.f
rtl/spt_pkg.sv
rtl/seeded_permutation_table_top.sv
verif/seeded_permutation_table_top_tb.sv
